// ===== hdl/mkey_pkg.sv =====
// ---------------------------------------------------------------------------
// Morse keyer package
// Shared constants, interface structs and the Morse code table.
// ---------------------------------------------------------------------------
package mkey_pkg;

    localparam int TEXT_DEPTH = 64;
    localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
    localparam int TEXT_LEN_W = 7;
    localparam int DOT_W      = 16;
    localparam int CNT_W      = 18;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;

    // Input commands
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_DOT     = 3'd1;
    localparam logic [2:0] CMD_DASH    = 3'd2;
    localparam logic [2:0] CMD_RELEASE = 3'd3;
    localparam logic [2:0] CMD_WRITE   = 3'd4;

    // Operating modes
    localparam logic [1:0] MODE_TEXT     = 2'd0;
    localparam logic [1:0] MODE_DOTS     = 2'd1;
    localparam logic [1:0] MODE_DASHES   = 2'd2;
    localparam logic [1:0] MODE_KEYBOARD = 2'd3;

    // Register indexes (byte address is four times the index)
    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_DOT_LENGTH  = 3'd1;
    localparam logic [2:0] REG_LOOP_ENABLE = 3'd2;
    localparam logic [2:0] REG_IAMBIC      = 3'd3;
    localparam logic [2:0] REG_TEXT_LENGTH = 3'd4;

    typedef struct packed {
        logic [1:0]            mode;
        logic [DOT_W-1:0]      dot_length;
        logic                  loop_enable;
        logic                  keyboard_iambic;
        logic [TEXT_LEN_W-1:0] text_length;
    } mkey_cfg_t;

    typedef struct packed {
        logic       mode_wr;
        logic [1:0] mode_val;
        logic       length_wr;
    } mkey_cfg_evt_t;

    typedef struct packed {
        logic       go;
        logic [2:0] cmd;
    } mkey_step_t;

    typedef struct packed {
        logic key_on;
        logic end_of_message;
    } mkey_result_t;

    // Element count and pattern. The pattern is left aligned: bit 5 is the
    // first element, and a one is a dash.
    typedef struct packed {
        logic [2:0] len;
        logic [5:0] pat;
    } morse_code_t;

    function automatic morse_code_t morse_lookup(input logic [6:0] ch);
        logic [6:0]  c;
        morse_code_t r;
        begin
            c = ch;
            if (ch >= 7'h61 && ch <= 7'h7A)
            begin
                c = ch - 7'd32;
            end
            case (c)
                7'h21: r = '{3'd6, 6'b101011};   // !
                7'h22: r = '{3'd6, 6'b010010};   // "
                7'h27: r = '{3'd6, 6'b011110};   // '
                7'h28: r = '{3'd5, 6'b101100};   // (
                7'h29: r = '{3'd6, 6'b101101};   // )
                7'h2B: r = '{3'd5, 6'b010100};   // +
                7'h2C: r = '{3'd6, 6'b110011};   // ,
                7'h2D: r = '{3'd6, 6'b100001};   // -
                7'h2E: r = '{3'd6, 6'b010101};   // .
                7'h2F: r = '{3'd5, 6'b100100};   // /
                7'h30: r = '{3'd5, 6'b111110};
                7'h31: r = '{3'd5, 6'b011110};
                7'h32: r = '{3'd5, 6'b001110};
                7'h33: r = '{3'd5, 6'b000110};
                7'h34: r = '{3'd5, 6'b000010};
                7'h35: r = '{3'd5, 6'b000000};
                7'h36: r = '{3'd5, 6'b100000};
                7'h37: r = '{3'd5, 6'b110000};
                7'h38: r = '{3'd5, 6'b111000};
                7'h39: r = '{3'd5, 6'b111100};
                7'h3A: r = '{3'd6, 6'b111000};   // :
                7'h3B: r = '{3'd6, 6'b101010};   // ;
                7'h3D: r = '{3'd5, 6'b100010};   // =
                7'h3F: r = '{3'd6, 6'b001100};   // ?
                7'h40: r = '{3'd6, 6'b011010};   // @
                7'h41: r = '{3'd2, 6'b010000};   // A
                7'h42: r = '{3'd4, 6'b100000};
                7'h43: r = '{3'd4, 6'b101000};
                7'h44: r = '{3'd3, 6'b100000};
                7'h45: r = '{3'd1, 6'b000000};
                7'h46: r = '{3'd4, 6'b001000};
                7'h47: r = '{3'd3, 6'b110000};
                7'h48: r = '{3'd4, 6'b000000};
                7'h49: r = '{3'd2, 6'b000000};
                7'h4A: r = '{3'd4, 6'b011100};
                7'h4B: r = '{3'd3, 6'b101000};
                7'h4C: r = '{3'd4, 6'b010000};
                7'h4D: r = '{3'd2, 6'b110000};
                7'h4E: r = '{3'd2, 6'b100000};
                7'h4F: r = '{3'd3, 6'b111000};
                7'h50: r = '{3'd4, 6'b011000};
                7'h51: r = '{3'd4, 6'b110100};
                7'h52: r = '{3'd3, 6'b010000};
                7'h53: r = '{3'd3, 6'b000000};
                7'h54: r = '{3'd1, 6'b100000};
                7'h55: r = '{3'd3, 6'b001000};
                7'h56: r = '{3'd4, 6'b000100};
                7'h57: r = '{3'd3, 6'b011000};
                7'h58: r = '{3'd4, 6'b100100};
                7'h59: r = '{3'd4, 6'b101100};
                7'h5A: r = '{3'd4, 6'b110000};   // Z
                default: r = '{3'd0, 6'b000000};
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hdl/mkey_regs.sv =====
// ---------------------------------------------------------------------------
// Morse keyer register file
// APB-style configuration registers with write events for the sequencer.
// ---------------------------------------------------------------------------
module mkey_regs
    import mkey_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output mkey_cfg_t         cfg,
    output mkey_cfg_evt_t     cfg_evt
);

    mkey_cfg_t  cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg     = cfg_reg;

    assign cfg_evt.mode_wr   = wr_en && (reg_idx == REG_MODE);
    assign cfg_evt.mode_val  = pwdata[1:0];
    assign cfg_evt.length_wr = wr_en && (reg_idx == REG_TEXT_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode            <= MODE_TEXT;
            cfg_reg.dot_length      <= 16'd2880;
            cfg_reg.loop_enable     <= 1'b0;
            cfg_reg.keyboard_iambic <= 1'b0;
            cfg_reg.text_length     <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:        cfg_reg.mode            <= pwdata[1:0];
                REG_DOT_LENGTH:  cfg_reg.dot_length      <= pwdata[DOT_W-1:0];
                REG_LOOP_ENABLE: cfg_reg.loop_enable     <= pwdata[0];
                REG_IAMBIC:      cfg_reg.keyboard_iambic <= pwdata[0];
                REG_TEXT_LENGTH: cfg_reg.text_length     <= pwdata[TEXT_LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:        prdata = APB_DW'(cfg_reg.mode);
            REG_DOT_LENGTH:  prdata = APB_DW'(cfg_reg.dot_length);
            REG_LOOP_ENABLE: prdata = APB_DW'(cfg_reg.loop_enable);
            REG_IAMBIC:      prdata = APB_DW'(cfg_reg.keyboard_iambic);
            REG_TEXT_LENGTH: prdata = APB_DW'(cfg_reg.text_length);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== hdl/mkey_text_store.sv =====
// ---------------------------------------------------------------------------
// Morse keyer text store
// Single-port-write memory for the message text with a registered read.
// ---------------------------------------------------------------------------
module mkey_text_store
    import mkey_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [TEXT_AW-1:0] wr_addr,
    input  logic [7:0]         wr_data,
    input  logic [TEXT_AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [TEXT_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mkey_core.sv =====
// ---------------------------------------------------------------------------
// Morse keyer sequencer
// Text sequencer, element timer and paddle state, advanced once per tick.
// ---------------------------------------------------------------------------
module mkey_core
    import mkey_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mkey_cfg_t          cfg,
    input  mkey_cfg_evt_t      cfg_evt,
    input  mkey_step_t         step,
    input  logic [7:0]         store_data,
    output logic [TEXT_AW-1:0] store_addr,
    output mkey_result_t       result
);

    typedef enum logic [2:0] {
        PH_START,
        PH_START_CHAR,
        PH_START_ELEM,
        PH_ELEM,
        PH_CHAR_SPACE,
        PH_WORD_SPACE,
        PH_END
    } text_phase_t;

    typedef enum logic [1:0] {
        EL_SILENT,
        EL_DOT,
        EL_DASH
    } elem_phase_t;

    typedef struct packed {
        elem_phase_t      phase;
        logic [CNT_W-1:0] cnt;
        logic             key;
    } elem_res_t;

    // One sample of the dot/dash element timer.
    function automatic elem_res_t elem_step(
        input elem_phase_t      ph,
        input logic [CNT_W-1:0] cnt,
        input logic             dot,
        input logic             dash,
        input logic [CNT_W-1:0] dlen
    );
        logic [CNT_W-1:0] on_len;
        logic [CNT_W-1:0] total;
        elem_res_t        r;
        begin
            r.phase = ph;
            r.cnt   = cnt;
            r.key   = 1'b0;
            on_len  = (ph == EL_DASH) ? CNT_W'((dlen << 1) + dlen) : dlen;
            total   = CNT_W'(on_len + dlen);
            unique case (ph)
                EL_SILENT:
                begin
                    if (dot)
                    begin
                        r.phase = EL_DOT;
                        r.cnt   = '0;
                    end
                    else if (dash)
                    begin
                        r.phase = EL_DASH;
                        r.cnt   = '0;
                    end
                end
                EL_DOT, EL_DASH:
                begin
                    if (cnt < on_len)
                    begin
                        r.key = 1'b1;
                        r.cnt = CNT_W'(cnt + 1'b1);
                    end
                    else if (cnt < total)
                    begin
                        r.cnt = CNT_W'(cnt + 1'b1);
                    end
                    else
                    begin
                        // Iambic alternation: the opposite paddle wins.
                        if (ph == EL_DOT)
                        begin
                            if (dash)
                                r.phase = EL_DASH;
                            else if (!dot)
                                r.phase = EL_SILENT;
                        end
                        else
                        begin
                            if (dot)
                                r.phase = EL_DOT;
                            else if (!dash)
                                r.phase = EL_SILENT;
                        end
                        r.cnt = '0;
                    end
                end
                default:
                begin
                    r.cnt = '0;
                end
            endcase
            return r;
        end
    endfunction

    text_phase_t           tph_reg, tph_next;
    elem_phase_t           eph_reg, eph_next;
    logic [TEXT_LEN_W-1:0] tpos_reg, tpos_next;
    logic [2:0]            epos_reg, epos_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [6:0]            cur_char_reg, cur_char_next;
    logic                  dot_held_reg, dot_held_next;
    logic                  dash_held_reg, dash_held_next;
    logic                  key_reg, key_next;

    logic [CNT_W-1:0]      dlen;
    logic [CNT_W-1:0]      space_len;
    logic [TEXT_LEN_W-1:0] eff_len;
    logic [6:0]            char_in;
    logic                  direct;
    morse_code_t           code;
    elem_res_t             er;

    assign dlen    = CNT_W'(cfg.dot_length);
    assign eff_len = (cfg.text_length > TEXT_LEN_W'(TEXT_DEPTH)) ?
                     TEXT_LEN_W'(TEXT_DEPTH) : cfg.text_length;
    assign direct  = (cfg.mode == MODE_KEYBOARD) && !cfg.keyboard_iambic;
    assign char_in = store_data[7] ? 7'd0 : store_data[6:0];

    always_comb
    begin
        tph_next       = tph_reg;
        eph_next       = eph_reg;
        tpos_next      = tpos_reg;
        epos_next      = epos_reg;
        cnt_next       = cnt_reg;
        cur_char_next  = cur_char_reg;
        dot_held_next  = dot_held_reg;
        dash_held_next = dash_held_reg;
        key_next       = key_reg;

        code      = morse_lookup(cur_char_reg);
        er        = elem_step(eph_reg, cnt_reg, dot_held_reg, dash_held_reg, dlen);
        space_len = (tph_reg == PH_CHAR_SPACE) ? CNT_W'(dlen << 1) : CNT_W'(dlen << 2);

        if (step.go)
        begin
            unique case (step.cmd)
                CMD_DOT:
                begin
                    dot_held_next  = 1'b1;
                    dash_held_next = 1'b0;
                    eph_next       = EL_SILENT;
                end
                CMD_DASH:
                begin
                    dot_held_next  = 1'b0;
                    dash_held_next = 1'b1;
                    eph_next       = EL_SILENT;
                end
                CMD_RELEASE:
                begin
                    dot_held_next  = 1'b0;
                    dash_held_next = 1'b0;
                end
                CMD_WRITE:
                begin
                    tph_next = PH_START;
                end
                CMD_TICK:
                begin
                    if (cfg.mode == MODE_TEXT)
                    begin
                        unique case (tph_reg)
                            PH_START:
                            begin
                                cnt_next       = '0;
                                epos_next      = '0;
                                tpos_next      = '0;
                                tph_next       = PH_START_CHAR;
                                key_next       = 1'b0;
                                dot_held_next  = 1'b0;
                                dash_held_next = 1'b0;
                            end
                            PH_START_CHAR:
                            begin
                                cnt_next  = '0;
                                epos_next = '0;
                                if (tpos_reg < eff_len)
                                begin
                                    cur_char_next = char_in;
                                    tph_next      = (char_in == 7'h20) ?
                                                    PH_WORD_SPACE : PH_START_ELEM;
                                    tpos_next     = TEXT_LEN_W'(tpos_reg + 1'b1);
                                end
                                else
                                begin
                                    tph_next = PH_END;
                                end
                            end
                            PH_START_ELEM:
                            begin
                                cnt_next = '0;
                                if (epos_reg >= code.len)
                                begin
                                    epos_next = '0;
                                    tph_next  = PH_CHAR_SPACE;
                                end
                                else
                                begin
                                    // The timer leaves silence at once with
                                    // its counter cleared and the key off.
                                    eph_next       = code.pat[3'd5 - epos_reg] ?
                                                     EL_DASH : EL_DOT;
                                    key_next       = 1'b0;
                                    dot_held_next  = 1'b0;
                                    dash_held_next = 1'b0;
                                    tph_next       = PH_ELEM;
                                    epos_next      = 3'(epos_reg + 1'b1);
                                end
                            end
                            PH_ELEM:
                            begin
                                eph_next = er.phase;
                                cnt_next = er.cnt;
                                key_next = er.key;
                                if (er.phase == EL_SILENT)
                                begin
                                    tph_next = PH_START_ELEM;
                                end
                            end
                            PH_CHAR_SPACE, PH_WORD_SPACE:
                            begin
                                if (cnt_reg < space_len)
                                begin
                                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                                    key_next = 1'b0;
                                end
                                else
                                begin
                                    tph_next = PH_START_CHAR;
                                end
                            end
                            PH_END:
                            begin
                                if (cfg.loop_enable)
                                begin
                                    tph_next = PH_START;
                                end
                                key_next       = 1'b0;
                                dot_held_next  = 1'b0;
                                dash_held_next = 1'b0;
                            end
                            default:
                            begin
                                key_next       = 1'b0;
                                dot_held_next  = 1'b0;
                                dash_held_next = 1'b0;
                            end
                        endcase
                    end
                    else if (!direct)
                    begin
                        eph_next = er.phase;
                        cnt_next = er.cnt;
                        key_next = er.key;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_evt.mode_wr)
        begin
            if (cfg_evt.mode_val == MODE_TEXT)
            begin
                tph_next = PH_START;
            end
            else
            begin
                dot_held_next  = (cfg_evt.mode_val == MODE_DOTS);
                dash_held_next = (cfg_evt.mode_val == MODE_DASHES);
                eph_next       = EL_SILENT;
            end
        end
        if (cfg_evt.length_wr)
        begin
            tph_next = PH_START;
        end
    end

    // Direct keying reports the paddles; a tick leaves them unchanged.
    assign result.key_on         = direct ? (dot_held_reg || dash_held_reg) : key_next;
    assign result.end_of_message = (tpos_next >= eff_len);

    // The store is read ahead at the position the text will hold next.
    assign store_addr = tpos_next[TEXT_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tph_reg       <= PH_START;
            eph_reg       <= EL_SILENT;
            tpos_reg      <= '0;
            epos_reg      <= '0;
            cnt_reg       <= '0;
            cur_char_reg  <= '0;
            dot_held_reg  <= 1'b0;
            dash_held_reg <= 1'b0;
            key_reg       <= 1'b0;
        end
        else
        begin
            tph_reg       <= tph_next;
            eph_reg       <= eph_next;
            tpos_reg      <= tpos_next;
            epos_reg      <= epos_next;
            cnt_reg       <= cnt_next;
            cur_char_reg  <= cur_char_next;
            dot_held_reg  <= dot_held_next;
            dash_held_reg <= dash_held_next;
            key_reg       <= key_next;
        end
    end

endmodule

// ===== hdl/morse_text_and_iambic_keyer.sv =====
// ---------------------------------------------------------------------------
// Morse text and iambic keyer
// Sample-rate CW keyer with text store, repeat modes and paddle keying.
// ---------------------------------------------------------------------------
// Usage: each transaction on the item channel carries a command. A sample
// tick (cmd 0) produces exactly one transaction on the result channel with
// the key state for that sample and the end-of-message flag. Paddle
// commands and text writes update state and produce no result.
// The item is captured in an input register, processed by one pass of
// logic and the result lands in an output register that raises
// result_valid; one item is accepted per cycle unless the receiver stalls.
// When the receiver stalls, the result is held and one more item waits in
// the input register; a non-tick item still passes through while the
// result is held. Configuration is written over the APB port while no
// transaction is in flight. Writing text mode or text_length restarts
// the text. Reset clears the sequencer, the paddles and the registers to
// their defaults (dot_length 2880). The text store has no reset and must
// be written before it is read; there is no clearing pass.
// ---------------------------------------------------------------------------
module morse_text_and_iambic_keyer
    import mkey_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [2:0]        cmd,
    input  logic [5:0]        text_index,
    input  logic [7:0]        text_char,
    output logic              result_valid,
    input  logic              result_ready,
    output logic              key_on,
    output logic              end_of_message
);

    mkey_cfg_t          cfg;
    mkey_cfg_evt_t      cfg_evt;
    mkey_step_t         step;
    mkey_result_t       core_res;
    logic [TEXT_AW-1:0] store_addr;
    logic [7:0]         store_data;

    logic               stage_valid_reg;
    logic [2:0]         stage_cmd_reg;
    logic [5:0]         stage_index_reg;
    logic [7:0]         stage_char_reg;
    logic               result_valid_reg;
    logic               key_on_reg;
    logic               eom_reg;
    logic               stage_go;
    logic               item_take;
    logic               tick_go;

    // A tick needs a free output register; other commands never wait.
    assign stage_go   = stage_valid_reg &&
                        ((stage_cmd_reg != CMD_TICK) || !result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || stage_go;
    assign item_take  = item_valid && item_ready;
    assign tick_go    = stage_go && (stage_cmd_reg == CMD_TICK);

    assign step.go  = stage_go;
    assign step.cmd = stage_cmd_reg;

    mkey_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_evt (cfg_evt)
    );

    mkey_text_store u_store (
        .clk     (clk),
        .wr_en   (stage_go && (stage_cmd_reg == CMD_WRITE)),
        .wr_addr (stage_index_reg[TEXT_AW-1:0]),
        .wr_data (stage_char_reg),
        .rd_addr (store_addr),
        .rd_data (store_data)
    );

    mkey_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_evt    (cfg_evt),
        .step       (step),
        .store_data (store_data),
        .store_addr (store_addr),
        .result     (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
                stage_valid_reg <= 1'b1;
            else if (stage_go)
                stage_valid_reg <= 1'b0;

            if (tick_go)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            stage_cmd_reg   <= cmd;
            stage_index_reg <= text_index;
            stage_char_reg  <= text_char;
        end
        if (tick_go)
        begin
            key_on_reg <= core_res.key_on;
            eom_reg    <= core_res.end_of_message;
        end
    end

    assign result_valid   = result_valid_reg;
    assign key_on         = key_on_reg;
    assign end_of_message = eom_reg;

endmodule

// ===== hdl/mkey_checker.sv =====
// ---------------------------------------------------------------------------
// Morse keyer port checker
// Concurrent assertions on the top-level ports, bound to the keyer.
// ---------------------------------------------------------------------------
module mkey_checker
    import mkey_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] prdata,
    input logic              pready,
    input logic              item_valid,
    input logic              item_ready,
    input logic [2:0]        cmd,
    input logic              result_valid,
    input logic              result_ready,
    input logic              key_on,
    input logic              end_of_message
);

    // A stalled result transaction keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(key_on) && $stable(end_of_message))
        else $error("result changed while stalled");

    // A new result stems from an accepted tick via the input and output registers.
    a_result_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready && (cmd == CMD_TICK), 2))
        else $error("result without a preceding tick");

    // The mode register reads back only its two bits.
    a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[APB_AW-1:2] == REG_MODE) |-> (prdata[APB_DW-1:2] == '0))
        else $error("mode readback has stray bits");

    // Writes always complete in the access cycle.
    a_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable |-> pready)
        else $error("configuration port inserted a wait state");

endmodule

bind morse_text_and_iambic_keyer mkey_checker u_checker (.*);

// ===== test/tb_morse_text_and_iambic_keyer.sv =====
// ---------------------------------------------------------------------------
// Testbench for the Morse text and iambic keyer
// A queue-fed driver sends commands to the keyer. A predictor in this file
// tracks the text sequencer, the element timer and the paddles, and forms
// the expected key state for every sample tick. A monitor compares each
// result transaction with the oldest expected one. The run steps through
// text, repeat-dot, repeat-dash and paddle modes with several speeds.
// ---------------------------------------------------------------------------
module tb_morse_text_and_iambic_keyer;
    import mkey_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
    localparam int         WATCHDOG_MAX  = 2000;

    typedef enum int {SEQ_START, SEQ_NEXT_CHAR, SEQ_NEXT_ELEM, SEQ_ELEM,
                      SEQ_CHAR_GAP, SEQ_WORD_GAP, SEQ_DONE} seq_phase_e;
    typedef enum int {EP_SILENT, EP_DOT, EP_DASH} elem_phase_e;
    typedef enum int {SYM_DOT, SYM_DASH, SYM_END} morse_sym_e;

    typedef struct {
        logic [2:0] cmd;
        logic [5:0] pos;
        logic [7:0] chr;
    } keyer_item_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              item_valid;
    logic              item_ready;
    logic [2:0]        cmd;
    logic [5:0]        text_index;
    logic [7:0]        text_char;
    logic              result_valid;
    logic              result_ready;
    logic              key_on;
    logic              end_of_message;

    // Predicted keyer state
    logic [1:0]        k_mode;
    logic [DOT_W-1:0]  k_dot_len;
    logic              k_loop;
    logic              k_iambic;
    logic [6:0]        k_text_len;
    logic [7:0]        k_store [TEXT_DEPTH];
    int unsigned       k_text_pos;
    int unsigned       k_elem_idx;
    int unsigned       k_count;
    logic [6:0]        k_char;
    seq_phase_e        k_seq;
    elem_phase_e       k_elem;
    logic              k_dot_down;
    logic              k_dash_down;
    logic              k_key;

    keyer_item_t       pending [$];
    mkey_result_t      keying_expected [$];
    int                mismatches;
    int                ticks_taken;
    int                others_taken;
    int                reg_writes;
    int                results_seen;
    int                stall_cycles;
    int                send_gap;
    int                hold_gap;
    bit                item_taken;
    bit                bursts_on;
    string             alphabet;

    morse_text_and_iambic_keyer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .cmd            (cmd),
        .text_index     (text_index),
        .text_char      (text_char),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .key_on         (key_on),
        .end_of_message (end_of_message)
    );

    always #5 clk = ~clk;

    // -----------------------------------------------------------------------
    // Keyer predictor
    // -----------------------------------------------------------------------
    function string morse_pattern(logic [7:0] c);
        case (c)
            "!":  return "-.-.--";
            "\"": return ".-..-.";
            "'":  return ".----.";
            "(":  return "-.--.";
            ")":  return "-.--.-";
            "+":  return ".-.-.";
            ",":  return "--..--";
            "-":  return "-....-";
            ".":  return ".-.-.-";
            "/":  return "-..-.";
            "0":  return "-----";
            "1":  return ".----";
            "2":  return "..---";
            "3":  return "...--";
            "4":  return "....-";
            "5":  return ".....";
            "6":  return "-....";
            "7":  return "--...";
            "8":  return "---..";
            "9":  return "----.";
            ":":  return "---...";
            ";":  return "-.-.-.";
            "=":  return "-...-";
            "?":  return "..--..";
            "@":  return ".--.-.";
            "A":  return ".-";
            "B":  return "-...";
            "C":  return "-.-.";
            "D":  return "-..";
            "E":  return ".";
            "F":  return "..-.";
            "G":  return "--.";
            "H":  return "....";
            "I":  return "..";
            "J":  return ".---";
            "K":  return "-.-";
            "L":  return ".-..";
            "M":  return "--";
            "N":  return "-.";
            "O":  return "---";
            "P":  return ".--.";
            "Q":  return "--.-";
            "R":  return ".-.";
            "S":  return "...";
            "T":  return "-";
            "U":  return "..-";
            "V":  return "...-";
            "W":  return ".--";
            "X":  return "-..-";
            "Y":  return "-.--";
            "Z":  return "--..";
            default: return "";
        endcase
    endfunction

    function morse_sym_e morse_symbol(logic [6:0] ch, int unsigned pos);
        logic [7:0] c;
        string      s;
        c = {1'b0, ch};
        if (c >= "a" && c <= "z")
            c = c - 8'd32;
        s = morse_pattern(c);
        if (pos >= s.len())
            return SYM_END;
        return (s[pos] == "-") ? SYM_DASH : SYM_DOT;
    endfunction

    function int unsigned text_limit();
        return (k_text_len < TEXT_DEPTH) ? k_text_len : TEXT_DEPTH;
    endfunction

    function void keyer_reset();
        k_mode      = MODE_TEXT;
        k_dot_len   = 16'd2880;
        k_loop      = 1'b0;
        k_iambic    = 1'b0;
        k_text_len  = '0;
        k_text_pos  = 0;
        k_elem_idx  = 0;
        k_count     = 0;
        k_char      = '0;
        k_seq       = SEQ_START;
        k_elem      = EP_SILENT;
        k_dot_down  = 1'b0;
        k_dash_down = 1'b0;
        k_key       = 1'b0;
    endfunction

    function void element_advance();
        int unsigned on_len;
        int unsigned total;
        if (k_elem == EP_SILENT)
        begin
            if (k_dot_down)
            begin
                k_elem  = EP_DOT;
                k_count = 0;
            end
            else if (k_dash_down)
            begin
                k_elem  = EP_DASH;
                k_count = 0;
            end
            k_key = 1'b0;
            return;
        end
        on_len = ((k_elem == EP_DOT) ? 1 : 3) * int'(k_dot_len);
        total  = on_len + int'(k_dot_len);
        if (k_count < on_len)
        begin
            k_key = 1'b1;
            k_count++;
        end
        else if (k_count < total)
        begin
            k_key = 1'b0;
            k_count++;
        end
        else
        begin
            // At the end of an element the opposite paddle wins, which is
            // what makes squeeze keying alternate.
            if (k_elem == EP_DOT)
            begin
                if (k_dash_down)
                    k_elem = EP_DASH;
                else if (!k_dot_down)
                    k_elem = EP_SILENT;
            end
            else
            begin
                if (k_dot_down)
                    k_elem = EP_DOT;
                else if (!k_dash_down)
                    k_elem = EP_SILENT;
            end
            k_count = 0;
            k_key   = 1'b0;
        end
    endfunction

    function void text_advance();
        logic [7:0]  ch;
        morse_sym_e  sym;
        int unsigned gap;
        case (k_seq)
            SEQ_START:
            begin
                k_count     = 0;
                k_elem_idx  = 0;
                k_text_pos  = 0;
                k_seq       = SEQ_NEXT_CHAR;
                k_key       = 1'b0;
                k_dot_down  = 1'b0;
                k_dash_down = 1'b0;
            end
            SEQ_NEXT_CHAR:
            begin
                k_count    = 0;
                k_elem_idx = 0;
                if (k_text_pos < text_limit())
                begin
                    ch     = k_store[k_text_pos % TEXT_DEPTH];
                    k_char = ch[7] ? 7'd0 : ch[6:0];
                    k_seq  = (k_char == " ") ? SEQ_WORD_GAP : SEQ_NEXT_ELEM;
                    k_text_pos++;
                end
                else
                begin
                    k_seq = SEQ_DONE;
                end
            end
            SEQ_NEXT_ELEM:
            begin
                k_count = 0;
                sym     = morse_symbol(k_char, k_elem_idx);
                if (sym == SYM_END)
                begin
                    k_elem_idx = 0;
                    k_seq      = SEQ_CHAR_GAP;
                end
                else
                begin
                    // The element timer is started as if a paddle were
                    // pressed for one sample.
                    k_dot_down  = (sym == SYM_DOT);
                    k_dash_down = (sym == SYM_DASH);
                    k_elem      = EP_SILENT;
                    element_advance();
                    k_dot_down  = 1'b0;
                    k_dash_down = 1'b0;
                    k_seq       = SEQ_ELEM;
                    k_elem_idx  = (k_elem_idx + 1) & 7;
                end
            end
            SEQ_ELEM:
            begin
                element_advance();
                if (k_elem == EP_SILENT)
                    k_seq = SEQ_NEXT_ELEM;
            end
            SEQ_CHAR_GAP, SEQ_WORD_GAP:
            begin
                gap = ((k_seq == SEQ_CHAR_GAP) ? 2 : 4) * int'(k_dot_len);
                if (k_count < gap)
                begin
                    k_count++;
                    k_key = 1'b0;
                end
                else
                begin
                    k_seq = SEQ_NEXT_CHAR;
                end
            end
            default:
            begin
                if (k_loop)
                    k_seq = SEQ_START;
                k_key       = 1'b0;
                k_dot_down  = 1'b0;
                k_dash_down = 1'b0;
            end
        endcase
    endfunction

    function void keyer_config(logic [2:0] idx, logic [31:0] value);
        case (idx)
            REG_MODE:
            begin
                k_mode = value[1:0];
                if (k_mode == MODE_TEXT)
                begin
                    k_seq = SEQ_START;
                end
                else
                begin
                    k_dot_down  = (k_mode == MODE_DOTS);
                    k_dash_down = (k_mode == MODE_DASHES);
                    k_elem      = EP_SILENT;
                end
            end
            REG_DOT_LENGTH:  k_dot_len = value[DOT_W-1:0];
            REG_LOOP_ENABLE: k_loop = value[0];
            REG_IAMBIC:      k_iambic = value[0];
            REG_TEXT_LENGTH:
            begin
                k_text_len = value[6:0];
                k_seq      = SEQ_START;
            end
            default: ;
        endcase
    endfunction

    function logic [31:0] keyer_reg_value(logic [2:0] idx);
        case (idx)
            REG_MODE:        return {30'd0, k_mode};
            REG_DOT_LENGTH:  return {16'd0, k_dot_len};
            REG_LOOP_ENABLE: return {31'd0, k_loop};
            REG_IAMBIC:      return {31'd0, k_iambic};
            REG_TEXT_LENGTH: return {25'd0, k_text_len};
            default:         return '0;
        endcase
    endfunction

    function void keyer_step(input logic [2:0] c, input logic [5:0] idx,
                             input logic [7:0] chr, output bit produced,
                             output mkey_result_t res);
        produced = 1'b0;
        res      = '0;
        case (c)
            CMD_DOT:
            begin
                k_dot_down  = 1'b1;
                k_dash_down = 1'b0;
                k_elem      = EP_SILENT;
            end
            CMD_DASH:
            begin
                k_dot_down  = 1'b0;
                k_dash_down = 1'b1;
                k_elem      = EP_SILENT;
            end
            CMD_RELEASE:
            begin
                k_dot_down  = 1'b0;
                k_dash_down = 1'b0;
            end
            CMD_WRITE:
            begin
                k_store[idx] = chr;
                k_seq        = SEQ_START;
            end
            CMD_TICK:
            begin
                if (k_mode == MODE_TEXT)
                begin
                    text_advance();
                    res.key_on = k_key;
                end
                else if (k_mode == MODE_KEYBOARD && !k_iambic)
                begin
                    res.key_on = k_dot_down | k_dash_down;
                end
                else
                begin
                    element_advance();
                    res.key_on = k_key;
                end
                res.end_of_message = (k_text_pos >= text_limit());
                produced = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function void queue_item(logic [2:0] c, logic [5:0] p, logic [7:0] ch);
        keyer_item_t it;
        it.cmd = c;
        it.pos = p;
        it.chr = ch;
        pending.push_back(it);
    endfunction

    function logic [7:0] pick_char();
        if ($urandom_range(0, 99) < 80)
            return alphabet[$urandom_range(0, alphabet.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    function keyer_item_t noise_item();
        keyer_item_t it;
        int unsigned r;
        r      = $urandom_range(0, 99);
        it.pos = 6'($urandom);
        it.chr = 8'($urandom);
        if (r < 30)
            it.cmd = CMD_DOT;
        else if (r < 60)
            it.cmd = CMD_DASH;
        else if (r < 85)
            it.cmd = CMD_RELEASE;
        else if (r < 93)
            it.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        else
            it.cmd = CMD_WRITE;
        return it;
    endfunction

    function void queue_ticks(int n, int noise_pct);
        keyer_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.cmd = CMD_TICK;
            it.pos = 6'($urandom);
            it.chr = 8'($urandom);
            if ($urandom_range(0, 99) < noise_pct)
                it = noise_item();
            pending.push_back(it);
        end
    endfunction

    // Wait until every queued transaction is through and every expected
    // result has arrived, then give non-tick items time to leave the block.
    task automatic settle();
        while (pending.size() != 0 || item_valid || keying_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        keyer_config(idx, value);
        reg_writes++;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        want = keyer_reg_value(idx);
        if (prdata !== want)
        begin
            if (mismatches < 10)
                $display("register %0d reads 0x%08h, expected 0x%08h", idx, prdata, want);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Item driver
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit           produced;
        mkey_result_t res;
        if (item_valid && item_ready)
        begin
            keyer_step(cmd, text_index, text_char, produced, res);
            if (produced)
            begin
                keying_expected.push_back(res);
                ticks_taken++;
            end
            else
            begin
                others_taken++;
            end
            item_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        keyer_item_t nxt;
        if (rst_n && !(item_valid && !item_taken))
        begin
            item_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending.size() != 0 && bursts_on && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 2);
                item_valid <= 1'b0;
            end
            else if (pending.size() != 0)
            begin
                nxt = pending.pop_front();
                cmd        <= nxt.cmd;
                text_index <= nxt.pos;
                text_char  <= nxt.chr;
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_gap > 0)
            begin
                hold_gap--;
                result_ready <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 9) == 0)
            begin
                hold_gap = $urandom_range(0, 2);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        mkey_result_t want;
        if (result_valid && result_ready)
        begin
            if (keying_expected.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d arrived with no tick outstanding", results_seen);
                mismatches++;
            end
            else
            begin
                want = keying_expected.pop_front();
                if (key_on !== want.key_on || end_of_message !== want.end_of_message)
                begin
                    if (mismatches < 10)
                        $display("result %0d: key_on %0b (expected %0b), end_of_message %0b (expected %0b)",
                                 results_seen, key_on, want.key_on,
                                 end_of_message, want.end_of_message);
                    mismatches++;
                end
            end
            results_seen++;
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) || psel)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_MAX)
        begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     stall_cycles, keying_expected.size());
            $display("** morse_text_and_iambic_keyer: FAILED **");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial
    begin
        logic [7:0] opening_text [12];
        int unsigned len;
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        item_valid   = 1'b0;
        cmd          = CMD_TICK;
        text_index   = '0;
        text_char    = '0;
        result_ready = 1'b0;
        mismatches   = 0;
        ticks_taken  = 0;
        others_taken = 0;
        reg_writes   = 0;
        results_seen = 0;
        stall_cycles = 0;
        send_gap     = 0;
        hold_gap     = 0;
        item_taken   = 1'b0;
        bursts_on    = 1'b1;
        alphabet     = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!\"'()+,-./:;=?@ etaoinsz";
        keyer_reset();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset state first: empty text, so every tick reports end of message.
        queue_ticks(3, 0);
        queue_item(CMD_DOT, '0, '0);
        queue_item(CMD_TICK, '0, '0);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            queue_item(3'(c), 6'h3F, 8'hFF);
        queue_item(CMD_RELEASE, '0, '0);
        queue_item(CMD_TICK, '0, '0);

        // Upper and lower case, a word space, the parentheses, a Latin-1
        // code, characters with no Morse entry and a six-element symbol.
        opening_text = '{"A", "e", " ", "5", "(", ")", 8'hC9, "#", "?", 8'h00,
                         8'h7F, "Z"};
        foreach (opening_text[i])
            queue_item(CMD_WRITE, 6'(i), opening_text[i]);
        queue_item(CMD_WRITE, 6'd63, 8'hFF);
        settle();

        reg_write(REG_DOT_LENGTH, 32'd1);
        reg_write(REG_TEXT_LENGTH, 32'd12);
        reg_write(REG_LOOP_ENABLE, 32'd1);
        queue_ticks(250, 0);
        settle();

        // Zero dot length collapses every timed segment.
        reg_write(REG_DOT_LENGTH, 32'd0);
        queue_ticks(60, 3);
        settle();

        reg_write(REG_MODE, {30'd0, MODE_DOTS});
        reg_write(REG_DOT_LENGTH, 32'd65535);
        reg_write(REG_TEXT_LENGTH, 32'd0);
        queue_ticks(20, 0);
        settle();

        reg_write(REG_DOT_LENGTH, 32'd2);
        reg_write(REG_MODE, {30'd0, MODE_DASHES});
        queue_ticks(40, 5);
        settle();

        reg_write(REG_MODE, {30'd0, MODE_KEYBOARD});
        reg_write(REG_IAMBIC, 32'd0);
        queue_ticks(80, 20);
        settle();

        reg_write(REG_IAMBIC, 32'd1);
        reg_write(REG_DOT_LENGTH, 32'($urandom_range(1, 3)));
        queue_ticks(150, 12);
        settle();

        // Fill the whole store so that any length is safe from here on.
        for (int i = 0; i < TEXT_DEPTH; i++)
            queue_item(CMD_WRITE, 6'(i), pick_char());
        settle();
        reg_write(REG_MODE, {30'd0, MODE_TEXT});
        reg_write(REG_TEXT_LENGTH, 32'd64);
        reg_write(REG_DOT_LENGTH, 32'd1);
        queue_ticks(200, 1);
        settle();

        // A length beyond the store depth is clamped to the depth.
        reg_write(REG_TEXT_LENGTH, 32'd127);
        reg_write(REG_LOOP_ENABLE, 32'd0);
        queue_ticks(60, 0);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            if (p == 3)
                bursts_on = 1'b0;
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
                queue_item(CMD_WRITE, 6'(i), pick_char());
            settle();
            reg_write(REG_DOT_LENGTH, 32'($urandom_range(1, 3)));
            reg_write(REG_LOOP_ENABLE, 32'($urandom_range(0, 1)));
            reg_write(REG_TEXT_LENGTH, 32'(len));
            reg_write(REG_MODE, {30'd0, MODE_TEXT});
            queue_ticks(100, 2);
            settle();
        end

        repeat (8) @(posedge clk);
        $display("Checked %0d key samples and %0d paddle, text and spare commands", ticks_taken,
                 others_taken);
        $display("across text, dot, dash and paddle modes with %0d register writes; %0d mismatches.",
                 reg_writes, mismatches);
        if (mismatches == 0)
        begin
            $display("** morse_text_and_iambic_keyer: PASSED **");
        end
        else
        begin
            $display("** morse_text_and_iambic_keyer: FAILED **");
        end
        $finish;
    end

endmodule
